[rtl/core/pointwise_conv_space_time_shuffle_macros.svh]
// ============================================================================
// Assertion macros for the pointwise convolution and space-time shuffle block
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ============================================================================
`ifndef POINTWISE_CONV_SPACE_TIME_SHUFFLE_MACROS_SVH
`define POINTWISE_CONV_SPACE_TIME_SHUFFLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pcst_pkg.sv]
// ============================================================================
// pcst_pkg
// Types and constants shared by the pointwise convolution and shuffle block.
// ============================================================================
`default_nettype none

package pcst_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 14;
    localparam int ACC_W      = 36;
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [0:0] REG_CHANNEL_COUNT = 1'b0;
    localparam logic [0:0] REG_TIME_RATIO    = 1'b1;

    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd4;
    localparam logic [1:0] TIME_RATIO_RST    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MAC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic add;
        logic mul;
    } t_mac_ctl;

endpackage

`default_nettype wire

[rtl/core/pcst_mac.sv]
// ============================================================================
// pcst_mac
// Shared multiply-accumulate unit with rounding of Q2.14 weight products and saturation.
// ============================================================================
`default_nettype none

module pcst_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire pcst_pkg::t_mac_ctl                    i_ctl,
    input  wire logic signed [pcst_pkg::DATA_W-1:0]    i_bias,
    input  wire logic signed [pcst_pkg::DATA_W-1:0]    i_weight,
    input  wire logic signed [pcst_pkg::DATA_W-1:0]    i_sample,
    output logic      signed [pcst_pkg::DATA_W-1:0]    o_result
);

    localparam logic signed [31:0] SAT_HI = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;
    localparam int EXT_W = pcst_pkg::ACC_W - pcst_pkg::DATA_W - pcst_pkg::FRAC_W;

    logic signed [2*pcst_pkg::DATA_W-1:0] r_prod;
    logic signed [pcst_pkg::ACC_W-1:0]    r_acc;
    logic signed [pcst_pkg::ACC_W-1:0]    w_round;
    logic signed [pcst_pkg::Q_W-1:0]      w_q;
    logic signed [31:0]                   w_qx;
    logic signed [31:0]                   w_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_weight * i_sample;
        end
        if (i_ctl.load) begin
            r_acc <= {{EXT_W{i_bias[pcst_pkg::DATA_W-1]}}, i_bias, {pcst_pkg::FRAC_W{1'b0}}};
        end else if (i_ctl.add) begin
            r_acc <= r_acc + pcst_pkg::ACC_W'(r_prod);
        end
    end

    always_comb begin
        w_round = r_acc + pcst_pkg::ACC_W'(pcst_pkg::ROUND_HALF);
        w_q     = w_round[pcst_pkg::ACC_W-1:pcst_pkg::FRAC_W];
        w_qx    = 32'(w_q);
        if (w_qx > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_qx < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_qx;
        end
        o_result = w_sat[pcst_pkg::DATA_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/core/pointwise_conv_space_time_shuffle.sv]
// ============================================================================
// pointwise_conv_space_time_shuffle
// Pointwise projection of a voxel followed by a channel-to-space-time shuffle.
// ============================================================================
// Weight and bias writes, and every sample except that of the last channel in
// use, leave the input ready for the next item. The last sample of a voxel
// starts a run of 4*C results (8*C when the time ratio is two or three and
// the frame is not zero), where C is the channel count in use. Each result
// goes through the single shared multiply-accumulate unit: an issue state
// that addresses the weight and bias memories, multiply and accumulate, and
// an emit state that hands the result to the output register once the output
// side is free. The input is not ready while a run is in progress. The weight
// and bias memories are not cleared at reset and must be written before use.
`default_nettype none

module pointwise_conv_space_time_shuffle #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // table_index[8:0], data_value[24:9], in_channel[27:25], pos_x[39:28],
    // pos_y[51:40], pos_frame[61:52], zero fill [63:62]
    input  wire logic [63:0] i_s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_x[12:0], out_y[25:13], out_frame[36:26], out_channel[39:37],
    // out_value[55:40]
    output logic [55:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BDEPTH = MAX_CHANNELS * 8;
    localparam int BA_W   = $clog2(BDEPTH);
    localparam int WDEPTH = MAX_CHANNELS * MAX_CHANNELS * 8;
    localparam int WA_W   = $clog2(WDEPTH);

    // Configuration registers
    logic [3:0] r_cc;
    logic [1:0] r_tr;
    logic       w_cfg_wr;

    // Input item fields
    logic                                   w_s_acc;
    logic [1:0]                             w_cmd;
    logic [8:0]                             w_idx;
    logic signed [pcst_pkg::DATA_W-1:0]     w_val;
    logic [2:0]                             w_ch;
    logic [11:0]                            w_px;
    logic [11:0]                            w_py;
    logic [9:0]                             w_pf;
    logic [CNT_W-1:0]                       w_nc;
    logic                                   w_start;

    // Sequencer state
    pcst_pkg::t_state r_state;
    pcst_pkg::t_state n_state;
    pcst_pkg::t_mac_ctl w_ctl;
    logic             w_load_out;

    // Per-voxel context and loop counters
    logic [CNT_W-1:0] r_nc;
    logic             r_r2;
    logic             r_two_ot;
    logic [11:0]      r_px;
    logic [11:0]      r_py;
    logic [9:0]       r_pf;
    logic [CH_W-1:0]  r_c;
    logic             r_oy;
    logic             r_ox;
    logic             r_ot;
    logic [CH_W-1:0]  r_ci;
    logic [CNT_W-1:0] r_k;
    logic             w_last;
    logic [2:0]       w_sidx;
    logic [BA_W-1:0]  w_pc;
    logic [WA_W-1:0]  w_waddr;
    logic [10:0]      w_frame;

    // Memories and their read registers
    logic signed [pcst_pkg::DATA_W-1:0] r_wmem [WDEPTH];
    logic signed [pcst_pkg::DATA_W-1:0] r_bmem [BDEPTH];
    logic signed [pcst_pkg::DATA_W-1:0] r_vbuf [MAX_CHANNELS];
    logic signed [pcst_pkg::DATA_W-1:0] r_wq;
    logic signed [pcst_pkg::DATA_W-1:0] r_bq;
    logic signed [pcst_pkg::DATA_W-1:0] r_vq;
    logic signed [pcst_pkg::DATA_W-1:0] w_result;

    // Output register
    logic                               r_ovalid;
    logic                               r_olast;
    logic [12:0]                        r_ox_pos;
    logic [12:0]                        r_oy_pos;
    logic [10:0]                        r_oframe;
    logic [2:0]                         r_och;
    logic signed [pcst_pkg::DATA_W-1:0] r_oval;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= pcst_pkg::CHANNEL_COUNT_RST;
            r_tr <= pcst_pkg::TIME_RATIO_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                pcst_pkg::REG_CHANNEL_COUNT: r_cc <= pwdata[3:0];
                pcst_pkg::REG_TIME_RATIO:    r_tr <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pcst_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, r_cc};
            pcst_pkg::REG_TIME_RATIO:    prdata = {30'd0, r_tr};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------------
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd   = i_s_axis_tuser;
    assign w_idx   = i_s_axis_tdata[8:0];
    assign w_val   = i_s_axis_tdata[24:9];
    assign w_ch    = i_s_axis_tdata[27:25];
    assign w_px    = i_s_axis_tdata[39:28];
    assign w_py    = i_s_axis_tdata[51:40];
    assign w_pf    = i_s_axis_tdata[61:52];

    always_comb begin
        if (r_cc == 4'd0) begin
            w_nc = CNT_W'(1);
        end else if (int'(r_cc) > MAX_CHANNELS) begin
            w_nc = CNT_W'(MAX_CHANNELS);
        end else begin
            w_nc = CNT_W'(r_cc);
        end
    end

    assign w_start = w_s_acc && (w_cmd == pcst_pkg::CMD_SAMPLE)
                     && (int'(w_ch) == int'(w_nc) - 1);

    // ------------------------------------------------------------------------
    // Address generation
    // ------------------------------------------------------------------------
    assign w_sidx  = r_r2 ? {r_oy, r_ox, r_ot} : {1'b0, r_oy, r_ox};
    assign w_pc    = BA_W'(BA_W'(w_sidx) * BA_W'(r_nc) + BA_W'(r_c));
    assign w_waddr = WA_W'(WA_W'(w_pc) * WA_W'(r_nc) + WA_W'(r_ci));
    assign w_last  = (int'(r_c) == int'(r_nc) - 1) && r_oy && r_ox && (r_ot || !r_two_ot);
    assign w_frame = !r_r2 ? {1'b0, r_pf}
                   : ((r_pf == 10'd0) ? 11'd0 : ({r_pf, r_ot} - 11'd1));

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_s_acc && (w_cmd == pcst_pkg::CMD_WEIGHT) && ({1'b0, w_idx} < 10'(WDEPTH))) begin
            r_wmem[w_idx[WA_W-1:0]] <= w_val;
        end
        r_wq <= r_wmem[w_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && (w_cmd == pcst_pkg::CMD_BIAS) && ({1'b0, w_idx} < 10'(BDEPTH))) begin
            r_bmem[w_idx[BA_W-1:0]] <= w_val;
        end
        r_bq <= r_bmem[w_pc];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && (w_cmd == pcst_pkg::CMD_SAMPLE) && (int'(w_ch) < MAX_CHANNELS)) begin
            r_vbuf[w_ch[CH_W-1:0]] <= w_val;
        end
        r_vq <= r_vbuf[r_ci];
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        w_ctl           = '0;
        w_load_out      = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            pcst_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (w_start) begin
                    n_state = pcst_pkg::ST_ISSUE;
                end
            end
            pcst_pkg::ST_ISSUE: begin
                n_state = pcst_pkg::ST_MAC;
            end
            pcst_pkg::ST_MAC: begin
                w_ctl.mul  = (r_k < r_nc);
                w_ctl.load = (r_k == '0);
                w_ctl.add  = (r_k != '0);
                if (r_k == r_nc) begin
                    n_state = pcst_pkg::ST_EMIT;
                end
            end
            pcst_pkg::ST_EMIT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = w_last ? pcst_pkg::ST_IDLE : pcst_pkg::ST_ISSUE;
                end
            end
            default: begin
                n_state = pcst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_nc     <= w_nc;
            r_r2     <= r_tr[1];
            r_two_ot <= r_tr[1] && (w_pf != 10'd0);
            r_px     <= w_px;
            r_py     <= w_py;
            r_pf     <= w_pf;
            r_c      <= '0;
            r_oy     <= 1'b0;
            r_ox     <= 1'b0;
            r_ot     <= 1'b0;
        end else if (w_load_out && !w_last) begin
            if (r_two_ot && !r_ot) begin
                r_ot <= 1'b1;
            end else begin
                r_ot <= 1'b0;
                r_ox <= !r_ox;
                if (r_ox) begin
                    r_oy <= !r_oy;
                    if (r_oy) begin
                        r_c <= r_c + CH_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start || w_load_out) begin
            r_ci <= '0;
        end else if ((r_state == pcst_pkg::ST_ISSUE) || (r_state == pcst_pkg::ST_MAC)) begin
            if (int'(r_ci) != int'(r_nc) - 1) begin
                r_ci <= r_ci + CH_W'(1);
            end
        end
        if (r_state == pcst_pkg::ST_ISSUE) begin
            r_k <= '0;
        end else if (r_state == pcst_pkg::ST_MAC) begin
            r_k <= r_k + CNT_W'(1);
        end
    end

    pcst_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_bias   (r_bq),
        .i_weight (r_wq),
        .i_sample (r_vq),
        .o_result (w_result)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_ox_pos <= {r_px, r_ox};
            r_oy_pos <= {r_py, r_oy};
            r_oframe <= w_frame;
            r_och    <= 3'(r_c);
            r_oval   <= w_result;
            r_olast  <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {r_oval, r_och, r_oframe, r_oy_pos, r_ox_pos};

endmodule

`default_nettype wire

[rtl/core/pcst_checker.sv]
// ============================================================================
// pcst_checker
// Port-level checks for the pointwise convolution and shuffle block.
// ============================================================================
`default_nettype none

`include "pointwise_conv_space_time_shuffle_macros.svh"

module pcst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [55:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    // A stalled result keeps its place and its contents.
    `PCST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

    // Table writes never start a run of results.
    `PCST_ASSERT_NXT(a_table_write_ready, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != pcst_pkg::CMD_SAMPLE), o_s_axis_tready, "table write left the input not ready")

    // While a voxel is only partly delivered, no new item is taken.
    `PCST_ASSERT_IMP(a_busy_mid_voxel, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready, "input ready in the middle of a voxel")

endmodule

bind pointwise_conv_space_time_shuffle pcst_checker u_pcst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

[bench/pointwise_conv_space_time_shuffle_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// pointwise_conv_space_time_shuffle_checker
// Watches the input, output and register channels of the projection and
// shuffle block. It keeps its own copy of the weight, bias and voxel stores
// and of both registers, works out the output elements that each accepted
// item causes, and compares every accepted output item with the oldest
// element still owed.
// ============================================================================

module pointwise_conv_space_time_shuffle_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [55:0] i_m_tdata,
    input  wire logic        i_m_tlast,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int MAX_CH = 8;
    localparam int SPATIAL = 2;
    localparam int WEIGHT_DEPTH = 512;
    localparam int BIAS_DEPTH = 64;
    localparam int REPORT_LIMIT = 10;
    localparam longint SAT_HI = (longint'(1) <<< (pcst_pkg::DATA_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [12:0]        x;
        logic [12:0]        y;
        logic [10:0]        frame;
        logic [2:0]         chan;
        logic signed [15:0] value;
        logic               last;
    } t_element;

    logic signed [15:0] weight_mem [WEIGHT_DEPTH];
    logic signed [15:0] bias_mem [BIAS_DEPTH];
    logic signed [15:0] sample_mem [MAX_CH];
    logic [3:0]         count_reg = pcst_pkg::CHANNEL_COUNT_RST;
    logic [1:0]         ratio_reg = pcst_pkg::TIME_RATIO_RST;
    t_element           element_q [$];
    int                 fail_count = 0;

    function automatic int active_channels();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_CH) return MAX_CH;
        return int'(count_reg);
    endfunction

    function automatic int active_ratio();
        if (ratio_reg == 0) return 1;
        if (ratio_reg > 2) return 2;
        return int'(ratio_reg);
    endfunction

    function automatic void project_voxel(input logic [11:0] px, input logic [11:0] py,
                                          input logic [9:0] pf);
        int       nc;
        int       r;
        int       raw;
        int       pc;
        int       total;
        int       n;
        int       c;
        int       oy;
        int       ox;
        int       ot;
        int       ci;
        longint   acc;
        longint   q;
        t_element e;
        nc = active_channels();
        r = active_ratio();
        total = (r > 1 && pf == 0) ? 4 * nc : 4 * nc * r;
        n = 0;
        for (c = 0; c < nc; c++) begin
            for (oy = 0; oy < SPATIAL; oy++) begin
                for (ox = 0; ox < SPATIAL; ox++) begin
                    for (ot = 0; ot < r; ot++) begin
                        raw = int'(pf) * r + ot;
                        if (r > 1 && raw == 1) continue;
                        pc = ((oy * SPATIAL + ox) * r + ot) * nc + c;
                        acc = longint'(bias_mem[pc]) <<< pcst_pkg::FRAC_W;
                        for (ci = 0; ci < nc; ci++) begin
                            acc += longint'(sample_mem[ci]) * longint'(weight_mem[pc * nc + ci]);
                        end
                        q = (acc + pcst_pkg::ROUND_HALF) >>> pcst_pkg::FRAC_W;
                        if (q > SAT_HI) q = SAT_HI;
                        if (q < SAT_LO) q = SAT_LO;
                        e.x = 13'(int'(px) * SPATIAL + ox);
                        e.y = 13'(int'(py) * SPATIAL + oy);
                        e.frame = 11'((r > 1 && raw > 1) ? raw - 1 : raw);
                        e.chan = 3'(c);
                        e.value = 16'(q);
                        e.last = (n == total - 1);
                        element_q.push_back(e);
                        n++;
                    end
                end
            end
        end
    endfunction

    function automatic void take_item(input logic [1:0] cmd, input logic [63:0] word);
        logic [8:0]         idx;
        logic signed [15:0] val;
        logic [2:0]         ch;
        logic [11:0]        px;
        logic [11:0]        py;
        logic [9:0]         pf;
        {pf, py, px, ch, val, idx} = word[61:0];
        case (cmd)
            pcst_pkg::CMD_WEIGHT: weight_mem[idx] = val;
            pcst_pkg::CMD_BIAS: if (idx < BIAS_DEPTH) bias_mem[idx] = val;
            pcst_pkg::CMD_SAMPLE: begin
                sample_mem[ch] = val;
                if (int'(ch) == active_channels() - 1) project_voxel(px, py, pf);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_element got;
        t_element want;
        if (!i_rst_n) begin
            count_reg = pcst_pkg::CHANNEL_COUNT_RST;
            ratio_reg = pcst_pkg::TIME_RATIO_RST;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2:2])
                    pcst_pkg::REG_CHANNEL_COUNT: count_reg = i_pwdata[3:0];
                    pcst_pkg::REG_TIME_RATIO:    ratio_reg = i_pwdata[1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) take_item(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got.x = i_m_tdata[12:0];
                got.y = i_m_tdata[25:13];
                got.frame = i_m_tdata[36:26];
                got.chan = i_m_tdata[39:37];
                got.value = i_m_tdata[55:40];
                got.last = i_m_tlast;
                if (element_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("Unexpected output item: x=%0d y=%0d frame=%0d ch=%0d value=%0d last=%0d",
                                 got.x, got.y, got.frame, got.chan, got.value, got.last);
                    end
                end else begin
                    want = element_q.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("Mismatch: expected x=%0d y=%0d frame=%0d ch=%0d value=%0d last=%0d",
                                     want.x, want.y, want.frame, want.chan, want.value, want.last);
                            $display("          actual   x=%0d y=%0d frame=%0d ch=%0d value=%0d last=%0d",
                                     got.x, got.y, got.frame, got.chan, got.value, got.last);
                        end
                    end
                end
            end
        end
        o_pending = element_q.size();
        o_fail_count = fail_count;
    end

endmodule

[bench/pointwise_conv_space_time_shuffle_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// pointwise_conv_space_time_shuffle_test
// Drives weight, bias and sample items into the projection and shuffle block
// with bursty input and a stalling output, and changes both registers between
// phases while the block is idle. A short directed part covers the field
// extremes, rounding ties, saturation, the dropped head frame and ignored
// items; random voxels over several register settings follow. The checker
// beside the block predicts and compares; this module gives the verdict.
// ============================================================================

module pointwise_conv_space_time_shuffle_test;

    localparam int MAX_CH = 8;
    localparam int WEIGHT_DEPTH = 512;
    localparam int BIAS_DEPTH = 64;
    localparam int SAMPLE_TARGET = 360;
    localparam int PHASES = 8;
    localparam int DRAIN_CYCLES = MAX_CH + 8;
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [55:0] m_tdata;
    wire         m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    int          fail_count;
    int          pending;

    bit          weight_done [WEIGHT_DEPTH];
    bit          bias_done [BIAS_DEPTH];
    bit          sample_done [MAX_CH];
    logic [3:0]  count_set = pcst_pkg::CHANNEL_COUNT_RST;
    logic [1:0]  ratio_set = pcst_pkg::TIME_RATIO_RST;
    int          burst_left = 0;
    int          samples_sent = 0;
    int          rx_run = 0;
    int          rx_mode = 0;

    always #5 i_clk = ~i_clk;

    pointwise_conv_space_time_shuffle i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    pointwise_conv_space_time_shuffle_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The output side alternates between always ready, stalled and coin-flip stretches.
    always @(negedge i_clk) begin
        if (rx_run == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_run = (rx_mode == 1) ? $urandom_range(1, 12) : $urandom_range(10, 120);
        end
        rx_run--;
        m_tready <= (rx_mode == 0) || (rx_mode == 2 && $urandom_range(0, 1) == 1);
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_pos();
        case ($urandom_range(0, 3))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_frame();
        case ($urandom_range(0, 4))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic int used_channels();
        if (count_set == 0) return 1;
        if (count_set > MAX_CH) return MAX_CH;
        return int'(count_set);
    endfunction

    function automatic int used_ratio();
        if (ratio_set == 0) return 1;
        if (ratio_set > 2) return 2;
        return int'(ratio_set);
    endfunction

    function automatic logic [3:0] plan_count(input int phase);
        case (phase)
            0: return 4'd1;
            1: return 4'd8;
            2: return 4'd0;
            3: return 4'd15;
            4: return 4'd3;
            5: return 4'd6;
            6: return 4'd2;
            default: return 4'd8;
        endcase
    endfunction

    function automatic logic [1:0] plan_ratio(input int phase);
        case (phase)
            0: return 2'd1;
            1: return 2'd2;
            2: return 2'd0;
            3: return 2'd3;
            4: return 2'd1;
            5: return 2'd2;
            6: return 2'd3;
            default: return 2'd1;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [8:0] idx,
                             input logic [15:0] val, input logic [2:0] ch,
                             input logic [11:0] px, input logic [11:0] py,
                             input logic [9:0] pf);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pf, py, px, ch, val, idx};
        s_tuser <= cmd;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        burst_left--;
        if (cmd == pcst_pkg::CMD_WEIGHT) weight_done[idx] = 1'b1;
        if (cmd == pcst_pkg::CMD_BIAS && idx < BIAS_DEPTH) bias_done[idx] = 1'b1;
        if (cmd == pcst_pkg::CMD_SAMPLE) begin
            sample_done[ch] = 1'b1;
            samples_sent++;
        end
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] reg_id, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_id, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_id == pcst_pkg::REG_CHANNEL_COUNT) count_set = value[3:0];
        else ratio_set = value[1:0];
    endtask

    task automatic fill_tables(input int chans, input int ratio);
        int i;
        for (i = 0; i < 4 * ratio * chans * chans; i++) begin
            if (!weight_done[i]) begin
                send_item(pcst_pkg::CMD_WEIGHT, 9'(i), pick_word(), 3'($urandom),
                          12'($urandom), 12'($urandom), 10'($urandom));
            end
        end
        for (i = 0; i < 4 * ratio * chans; i++) begin
            if (!bias_done[i]) begin
                send_item(pcst_pkg::CMD_BIAS, 9'(i), pick_word(), 3'($urandom),
                          12'($urandom), 12'($urandom), 10'($urandom));
            end
        end
    endtask

    // A broken voxel skips the channels that already hold a value.
    task automatic send_voxel(input bit broken);
        int          chans;
        int          ofs;
        int          k;
        int          ch;
        logic [11:0] px;
        logic [11:0] py;
        logic [9:0]  pf;
        chans = used_channels();
        fill_tables(chans, used_ratio());
        px = pick_pos();
        py = pick_pos();
        pf = pick_frame();
        ofs = $urandom_range(0, MAX_CH - 1);
        for (k = 0; k < chans - 1; k++) begin
            ch = (k + ofs) % (chans - 1);
            if (!sample_done[ch] || !broken) begin
                send_item(pcst_pkg::CMD_SAMPLE, 9'($urandom), pick_word(), 3'(ch),
                          12'($urandom), 12'($urandom), 10'($urandom));
            end
        end
        if (chans < MAX_CH && $urandom_range(0, 3) == 0) begin
            send_item(pcst_pkg::CMD_SAMPLE, 9'($urandom), pick_word(),
                      3'($urandom_range(chans, MAX_CH - 1)),
                      12'($urandom), 12'($urandom), 10'($urandom));
        end
        send_item(pcst_pkg::CMD_SAMPLE, 9'($urandom), pick_word(), 3'(chans - 1), px, py, pf);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(CMD_NONE, 9'($urandom), 16'($urandom), 3'($urandom), 12'($urandom),
                         12'($urandom), 10'($urandom));
            1: send_item(pcst_pkg::CMD_BIAS, 9'($urandom_range(BIAS_DEPTH, 511)), 16'($urandom),
                         3'($urandom), 12'($urandom), 12'($urandom), 10'($urandom));
            2: send_item(pcst_pkg::CMD_WEIGHT, 9'($urandom), pick_word(), 3'($urandom),
                         12'($urandom), 12'($urandom), 10'($urandom));
            default: send_item(pcst_pkg::CMD_BIAS, 9'($urandom_range(0, BIAS_DEPTH - 1)),
                               pick_word(), 3'($urandom), 12'($urandom), 12'($urandom),
                               10'($urandom));
        endcase
    endtask

    initial begin
        #40_000_000;
        $display("pointwise_conv_space_time_shuffle_test NOT OK");
        $finish;
    end

    initial begin
        int phase;
        int phase_start;
        int roll;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Ignored items: unknown command and bias writes beyond the store.
        send_item(CMD_NONE, 9'h1FF, 16'hFFFF, 3'd7, 12'hFFF, 12'hFFF, 10'h3FF);
        send_item(pcst_pkg::CMD_BIAS, 9'd100, 16'h1234, 3'd0, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_BIAS, 9'h1FF, 16'h8000, 3'd5, 12'd7, 12'd9, 10'd3);
        fill_tables(used_channels(), used_ratio());

        // Half-way ties in both directions, a sample beyond the count and the head frame.
        send_item(pcst_pkg::CMD_WEIGHT, 9'd0, 16'h2000, 3'd0, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_WEIGHT, 9'd4, 16'hE000, 3'd0, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_SAMPLE, 9'd0, 16'h0001, 3'd0, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_SAMPLE, 9'd0, 16'h0000, 3'd1, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_SAMPLE, 9'd0, 16'h0000, 3'd2, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_SAMPLE, 9'd0, 16'h7FFF, 3'd7, 12'hFFF, 12'hFFF, 10'h3FF);
        send_item(pcst_pkg::CMD_SAMPLE, 9'd0, 16'h0000, 3'd3, 12'd0, 12'd0, 10'd0);

        // Full-scale samples and weights at the far corner, so the sums saturate.
        send_item(pcst_pkg::CMD_WEIGHT, 9'd1, 16'h7FFF, 3'd0, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_WEIGHT, 9'd2, 16'h8000, 3'd0, 12'd0, 12'd0, 10'd0);
        send_item(pcst_pkg::CMD_SAMPLE, 9'h1FF, 16'h7FFF, 3'd0, 12'hFFF, 12'hFFF, 10'h3FF);
        send_item(pcst_pkg::CMD_SAMPLE, 9'h1FF, 16'h8000, 3'd1, 12'hFFF, 12'hFFF, 10'h3FF);
        send_item(pcst_pkg::CMD_SAMPLE, 9'h1FF, 16'h7FFF, 3'd2, 12'hFFF, 12'hFFF, 10'h3FF);
        send_item(pcst_pkg::CMD_SAMPLE, 9'h1FF, 16'h8000, 3'd3, 12'hFFF, 12'hFFF, 10'h3FF);

        // Only the last channel, on frame one, so the stored channels are reused.
        send_item(pcst_pkg::CMD_SAMPLE, 9'd0, 16'h0100, 3'd3, 12'd1, 12'd2, 10'd1);

        for (phase = 0; phase < PHASES; phase++) begin
            drain_block();
            write_reg(pcst_pkg::REG_CHANNEL_COUNT, {$urandom} << 4 | 32'(plan_count(phase)));
            write_reg(pcst_pkg::REG_TIME_RATIO, {$urandom} << 2 | 32'(plan_ratio(phase)));
            phase_start = samples_sent;
            while (samples_sent - phase_start < SAMPLE_TARGET / PHASES) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) drain_block();
                else if (roll < 4) send_noise();
                else send_voxel(roll < 7);
            end
        end
        drain_block();

        if (fail_count == 0 && pending == 0) begin
            $display("pointwise_conv_space_time_shuffle_test OK");
        end else begin
            $display("pointwise_conv_space_time_shuffle_test NOT OK");
        end
        $finish;
    end

endmodule

[pointwise_conv_space_time_shuffle.f]
+incdir+rtl/core
rtl/core/pcst_pkg.sv
rtl/core/pcst_mac.sv
rtl/core/pointwise_conv_space_time_shuffle.sv
rtl/core/pcst_checker.sv
bench/pointwise_conv_space_time_shuffle_checker.sv
bench/pointwise_conv_space_time_shuffle_test.sv
